// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, quiet while arst_n is low.
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same check, but also active during reset.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/bmps_pkg.sv -----
// ----------------------------------------------------------------------------
// bmps_pkg
// Types and constants of the BLE MIDI packet splitter.
// ----------------------------------------------------------------------------
package bmps_pkg;

	// Field widths of a beat.
	localparam int BYTE_W = 8;
	localparam int HIGH_W = 6;
	localparam int LOW_W  = 7;
	localparam int TIME_W = HIGH_W + LOW_W;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_FIRST_TS = 3'd1,
		PH_AFTER_TS = 3'd2,
		PH_BODY     = 3'd3,
		PH_DROP     = 3'd4
	} phase_t;

	// Role of a result byte.
	typedef enum logic [1:0] {
		ROLE_TIME   = 2'd0,
		ROLE_STATUS = 2'd1,
		ROLE_DATA   = 2'd2,
		ROLE_REJECT = 2'd3
	} role_t;

	// One result beat.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [TIME_W-1:0] message_time;
		role_t             role;
		logic              packet_end;
	} result_t;

endpackage

// ----- rtl/core/bmps_parser.sv -----
// ----------------------------------------------------------------------------
// bmps_parser
// Phase machine that classifies each packet byte and tracks the timestamp.
// ----------------------------------------------------------------------------
module bmps_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [7:0]                  packet_byte,
	input  logic                        packet_last,
	output logic                        res_valid,
	output bmps_pkg::result_t           res
);
	import bmps_pkg::*;

	phase_t              phase_q, phase_d;
	logic [HIGH_W-1:0]   time_high_q, time_high_d;
	logic [TIME_W-1:0]   cur_time_q, cur_time_d;
	logic                is_data;
	logic [TIME_W-1:0]   new_time;

	assign is_data  = ~packet_byte[BYTE_W-1];
	assign new_time = {time_high_q, packet_byte[LOW_W-1:0]};

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			time_high_q <= '0;
			cur_time_q  <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			time_high_q <= time_high_d;
			cur_time_q  <= cur_time_d;
		end
	end

	// Next phase and the result for the byte at the input.
	always_comb begin
		phase_d            = phase_q;
		time_high_d        = time_high_q;
		cur_time_d         = cur_time_q;
		res_valid          = 1'b0;
		res.out_byte       = packet_byte;
		res.message_time   = cur_time_q;
		res.role           = ROLE_DATA;
		res.packet_end     = packet_last;
		unique case (phase_q)
			PH_FIRST_TS: begin
				res_valid = 1'b1;
				if (is_data) begin
					res.role         = ROLE_REJECT;
					res.message_time = '0;
					phase_d          = PH_DROP;
				end else begin
					cur_time_d       = new_time;
					res.message_time = new_time;
					res.role         = ROLE_TIME;
					phase_d          = PH_AFTER_TS;
				end
			end
			PH_AFTER_TS: begin
				res_valid = 1'b1;
				res.role  = is_data ? ROLE_DATA : ROLE_STATUS;
				phase_d   = PH_BODY;
			end
			PH_BODY: begin
				res_valid = 1'b1;
				if (!is_data) begin
					cur_time_d       = new_time;
					res.message_time = new_time;
					res.role         = ROLE_TIME;
					phase_d          = PH_AFTER_TS;
				end
			end
			PH_DROP: begin
				phase_d = PH_DROP;
			end
			default: begin
				// Header byte; unused phase codes behave the same way.
				if (is_data || packet_last) begin
					res_valid        = 1'b1;
					res.role         = ROLE_REJECT;
					res.message_time = '0;
					phase_d          = PH_DROP;
				end else begin
					time_high_d = packet_byte[HIGH_W-1:0];
					phase_d     = PH_FIRST_TS;
				end
			end
		endcase
		// The last byte of any packet rearms the header search.
		if (packet_last) begin
			phase_d = PH_HEADER;
		end
	end

endmodule

// ----- rtl/core/bmps_skid.sv -----
// ----------------------------------------------------------------------------
// bmps_skid
// Output register with one skid entry, so the input stall is registered.
// ----------------------------------------------------------------------------
module bmps_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bmps_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output bmps_pkg::result_t out_data
);
	import bmps_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop, load_out;

	assign pop       = out_valid_q & ~out_stall;
	assign load_out  = ~out_valid_q | pop;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Occupancy flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= skid_valid_q & push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Beat payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- rtl/core/ble_midi_packet_splitter.sv -----
// ----------------------------------------------------------------------------
// ble_midi_packet_splitter
// Splits BLE MIDI packets into timestamped, role-tagged bytes.
// ----------------------------------------------------------------------------
// Input channel: one packet byte per beat (packet_byte, packet_last), with
// in_valid / in_stall. Output channel: one tagged byte per beat (out_byte,
// message_time, byte_role, packet_end), with out_valid / out_stall.
// The header byte yields no beat unless the packet is rejected there; every
// later byte yields one beat, except the rest of a rejected packet.
// Each beat is registered in the output register, or in the skid entry.
// Throughput: one byte per cycle while in_stall is low, set by the phase machine.
// The output register plus one skid entry let a byte be taken while a result
// waits; in_stall rises only when both are full, and it is a register.
// Reset returns the parser to expecting a header and empties the output.
// While out_stall is high the output beat holds.
// ----------------------------------------------------------------------------
module ble_midi_packet_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  packet_byte,
	input  logic        packet_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [12:0] message_time,
	output logic [1:0]  byte_role,
	output logic        packet_end
);
	import bmps_pkg::*;

	logic    take;
	logic    res_valid;
	logic    full;
	result_t res;
	result_t out_data;

	assign in_stall = full;
	assign take     = in_valid & ~full;

	// Phase machine.
	bmps_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.packet_byte (packet_byte),
		.packet_last (packet_last),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register and skid entry.
	bmps_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take & res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign out_byte     = out_data.out_byte;
	assign message_time = out_data.message_time;
	assign byte_role    = out_data.role;
	assign packet_end   = out_data.packet_end;

endmodule

// ----- rtl/core/bmps_checker.sv -----
// ----------------------------------------------------------------------------
// bmps_checker
// Port-level checks of the splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic [12:0] message_time,
	input logic [1:0]  byte_role,
	input logic        packet_end
);
	import bmps_pkg::*;

	// A stalled output beat stays valid.
	`CHK_ASSERT(a_out_hold,
		out_valid && out_stall |=> out_valid,
		"output beat dropped while stalled")

	// A rejection carries a zero timestamp.
	`CHK_ASSERT(a_reject_time,
		out_valid && byte_role == ROLE_REJECT |-> message_time == '0,
		"rejected beat has nonzero time")

	// A timestamp beat is a non-data byte whose low bits are the time's low bits.
	`CHK_ASSERT(a_time_low,
		out_valid && byte_role == ROLE_TIME |->
			out_byte[7] && message_time[6:0] == out_byte[6:0],
		"timestamp beat inconsistent with its byte")

	// Data and status roles agree with bit 7 of the byte.
	`CHK_ASSERT(a_role_bit7,
		out_valid && (byte_role == ROLE_DATA || byte_role == ROLE_STATUS) |->
			out_byte[7] == (byte_role == ROLE_STATUS),
		"byte role disagrees with bit 7")

	// During reset the output is empty and in_stall is low.
	`CHK_ASSERT_ALWAYS(a_reset_empty,
		!arst_n |-> !out_valid && !in_stall,
		"output not empty during reset")

endmodule

bind ble_midi_packet_splitter bmps_checker u_bmps_checker (.*);

// ----- sim/tb_ble_midi_packet_splitter.sv -----
// ----------------------------------------------------------------------------
// tb_ble_midi_packet_splitter
// Self-checking bench for the BLE MIDI packet splitter.
// ----------------------------------------------------------------------------
// A short directed table covers the rejection paths, the extreme timestamps,
// status and data roles, a lone trailing timestamp and the dropping of a
// rejected packet. Random packets follow, mostly well formed with random
// content, the rest broken packets and noise. A parser model inside the bench
// predicts each tagged beat, and every output beat is compared against the
// oldest prediction. Both channels idle at random, with calm stretches too.
// ----------------------------------------------------------------------------
module tb_ble_midi_packet_splitter;
	timeunit 1ns;
	timeprecision 1ps;

	import bmps_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int PLAN_LEN = 25;

	// One row of the directed table: the input beat, and the expected beat
	// where it is written out by hand.
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       typed;
		result_t    want;
	} step_t;

	localparam step_t PLAN [PLAN_LEN] = '{
		'{8'h05, 1'b0, 1'b1, '{8'h05, 13'h0000, ROLE_REJECT, 1'b0}}, // data header
		'{8'h90, 1'b1, 1'b0, '0},                                  // dropped tail
		'{8'hBF, 1'b1, 1'b1, '{8'hBF, 13'h0000, ROLE_REJECT, 1'b1}}, // one-byte packet
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b1, 1'b1, '{8'h7F, 13'h0000, ROLE_REJECT, 1'b1}}, // data second byte
		'{8'hBF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, 13'h1FFF, ROLE_TIME,   1'b0}}, // highest time
		'{8'h90, 1'b0, 1'b1, '{8'h90, 13'h1FFF, ROLE_STATUS, 1'b0}},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 13'h1FFF, ROLE_DATA,   1'b0}},
		'{8'h7F, 1'b0, 1'b1, '{8'h7F, 13'h1FFF, ROLE_DATA,   1'b0}},
		'{8'h80, 1'b0, 1'b1, '{8'h80, 13'h1F80, ROLE_TIME,   1'b0}},
		'{8'h40, 1'b0, 1'b1, '{8'h40, 13'h1F80, ROLE_DATA,   1'b0}}, // running status
		'{8'hF0, 1'b0, 1'b1, '{8'hF0, 13'h1FF0, ROLE_TIME,   1'b0}},
		'{8'hF8, 1'b0, 1'b1, '{8'hF8, 13'h1FF0, ROLE_STATUS, 1'b0}},
		'{8'h81, 1'b1, 1'b1, '{8'h81, 13'h1F81, ROLE_TIME,   1'b1}},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b1, '{8'h80, 13'h0000, ROLE_TIME,   1'b1}}, // lone timestamp
		'{8'hC0, 1'b0, 1'b0, '0},
		'{8'h85, 1'b0, 1'b1, '{8'h85, 13'h0005, ROLE_TIME,   1'b0}},
		'{8'hC0, 1'b1, 1'b1, '{8'hC0, 13'h0005, ROLE_STATUS, 1'b1}},
		'{8'hAA, 1'b0, 1'b0, '0},
		'{8'h9B, 1'b1, 1'b0, '0},
		'{8'h01, 1'b0, 1'b1, '{8'h01, 13'h0000, ROLE_REJECT, 1'b0}},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h22, 1'b1, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  packet_byte;
	logic        packet_last;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic [12:0] message_time;
	logic [1:0]  byte_role;
	logic        packet_end;

	// Parser state as the bench tracks it.
	phase_t      rx_phase;
	logic [5:0]  hdr_high;
	logic [12:0] msg_time;

	result_t     pending_tags [$];
	int          errors;
	int          items_sent;
	bit          calm;

	ble_midi_packet_splitter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packet_byte  (packet_byte),
		.packet_last  (packet_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.message_time (message_time),
		.byte_role    (byte_role),
		.packet_end   (packet_end)
	);

	// The clock starts low so that the first rising edge falls inside reset.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Advances the parser by one byte; returns 1 when the byte yields a beat.
	function automatic bit split_byte(input logic [7:0] b, input logic last,
			output result_t beat);
		bit     is_data;
		bit     has;
		phase_t nxt;
		is_data = (b[7] == 1'b0);
		has = 1'b1;
		beat = '0;
		case (rx_phase)
			PH_FIRST_TS: begin
				if (is_data) begin
					beat = '{b, 13'd0, ROLE_REJECT, last};
					nxt = PH_DROP;
				end else begin
					msg_time = {hdr_high, b[6:0]};
					beat = '{b, msg_time, ROLE_TIME, last};
					nxt = PH_AFTER_TS;
				end
			end
			PH_AFTER_TS: begin
				beat = '{b, msg_time, is_data ? ROLE_DATA : ROLE_STATUS, last};
				nxt = PH_BODY;
			end
			PH_BODY: begin
				if (is_data) begin
					beat = '{b, msg_time, ROLE_DATA, last};
				end else begin
					msg_time = {hdr_high, b[6:0]};
					beat = '{b, msg_time, ROLE_TIME, last};
				end
				nxt = is_data ? PH_BODY : PH_AFTER_TS;
			end
			PH_DROP: begin
				has = 1'b0;
				nxt = PH_DROP;
			end
			default: begin
				if (is_data || last) begin
					beat = '{b, 13'd0, ROLE_REJECT, last};
					nxt = PH_DROP;
				end else begin
					hdr_high = b[5:0];
					has = 1'b0;
					nxt = PH_FIRST_TS;
				end
			end
		endcase
		rx_phase = last ? PH_HEADER : nxt;
		return has;
	endfunction

	// Sends one byte and records what it should produce. A hand-written
	// expectation, where given, stands in for the predicted one.
	task automatic push_byte(input logic [7:0] b, input logic last,
			input logic typed, input result_t want);
		int      gap;
		bit      has;
		result_t beat;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		packet_byte <= b;
		packet_last <= last;
		do @(posedge clk); while (in_stall);
		items_sent++;
		has = split_byte(b, last, beat);
		if (typed)
			pending_tags.push_back(want);
		else if (has)
			pending_tags.push_back(beat);
	endtask

	// Holds the sender off until every predicted beat has come out.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_tags.size() != 0);
	endtask

	// Builds one random packet and sends it.
	task automatic send_packet();
		logic [7:0] pkt [$];
		int         kind;
		int         n;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			// Well formed: header, then messages of timestamp, optional
			// status and a few data bytes.
			pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
			repeat ($urandom_range(1, 4)) begin
				pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
				if ($urandom_range(0, 1))
					pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
				repeat (n) pkt.push_back(8'($urandom_range(0, 127)));
			end
		end else if (kind < 88) begin
			// Broken: data header, one-byte packet or data second byte.
			case ($urandom_range(0, 2))
				0: pkt.push_back(8'($urandom_range(0, 127)));
				1: ;
				default: begin
					pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
					pkt.push_back(8'($urandom_range(0, 127)));
				end
			endcase
			if (pkt.size() == 0)
				pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
			else
				repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(0, 255)));
		end else begin
			// Noise.
			repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
		end
		foreach (pkt[i])
			push_byte(pkt[i], i == pkt.size() - 1, 1'b0, '0);
	endtask

	// Output stall: random runs, held low in calm stretches.
	initial begin
		int run_left;
		run_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (run_left != 0) begin
				run_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
				run_left = 4;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				run_left = pick_gap();
			end
		end
	end

	// Compares each accepted output beat with the oldest prediction.
	always @(posedge clk) begin : check_out
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tags.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat byte=%h time=%h role=%0d end=%b",
					$time, out_byte, message_time, byte_role, packet_end);
			end else begin
				want = pending_tags.pop_front();
				if (out_byte !== want.out_byte) begin
					errors++;
					$display("%0t: out_byte expected %h actual %h",
						$time, want.out_byte, out_byte);
				end
				if (message_time !== want.message_time) begin
					errors++;
					$display("%0t: message_time expected %h actual %h",
						$time, want.message_time, message_time);
				end
				if (byte_role !== want.role) begin
					errors++;
					$display("%0t: byte_role expected %0d actual %0d",
						$time, want.role, byte_role);
				end
				if (packet_end !== want.packet_end) begin
					errors++;
					$display("%0t: packet_end expected %b actual %b",
						$time, want.packet_end, packet_end);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random packets, wind-down.
	initial begin
		int packets;
		arst_n = 1'b0;
		in_valid = 1'b0;
		packet_byte = 8'h00;
		packet_last = 1'b0;
		rx_phase = PH_HEADER;
		hdr_high = '0;
		msg_time = '0;
		errors = 0;
		items_sent = 0;
		calm = 1'b0;
		packets = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++)
			push_byte(PLAN[i].b, PLAN[i].last, PLAN[i].typed, PLAN[i].want);
		drain();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			send_packet();
			packets++;
			if (packets % 10 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (packets % 40 == 0)
				drain();
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bmps_pkg.sv
rtl/core/bmps_parser.sv
rtl/core/bmps_skid.sv
rtl/core/ble_midi_packet_splitter.sv
rtl/core/bmps_checker.sv
sim/tb_ble_midi_packet_splitter.sv
